@@ rtl/bis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

    // field widths
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned CNT_W       = 9;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 48;

    // capacity after reset
    localparam logic [CNT_W-1:0] CAPACITY_RST = 9'd256;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_READ   = 2'd2,
        OP_SEARCH = 2'd3
    } opcode_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_go;
        logic scan_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/bis_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bis_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bis_pkg::ctrl_sts_t sts,
    output bis_pkg::ctrl_cmd_t     cmd
);

    bis_pkg::state_t state_reg;
    bis_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sts.search_go ? bis_pkg::ST_SCAN : bis_pkg::ST_RESULT;
                end
            end
            bis_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = bis_pkg::ST_RESULT;
                end
            end
            bis_pkg::ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = bis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bis_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        s_tready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            bis_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            bis_pkg::ST_RESULT:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/bis_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bis_datapath #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire bis_pkg::ctrl_cmd_t                    cmd,
    output bis_pkg::ctrl_sts_t                         sts,
    input  wire logic [bis_pkg::IN_TDATA_W-1:0]        s_tdata,
    input  wire logic                                  cfg_valid,
    input  wire logic [bis_pkg::CNT_W-1:0]             cfg_data,
    input  wire logic                                  m_tready,
    output logic                                       m_tvalid,
    output logic [bis_pkg::OUT_TDATA_W-1:0]            m_tdata
);

    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned LIM_INT = (DEPTH > 511) ? 511 : DEPTH;
    localparam logic [bis_pkg::CNT_W-1:0] DEPTH_LIM = bis_pkg::CNT_W'(LIM_INT);

    // entry store
    logic [bis_pkg::DATA_W-1:0] mem [DEPTH];

    bis_pkg::opcode_t            in_op;
    logic [bis_pkg::DATA_W-1:0]  in_value;
    logic [bis_pkg::POS_W-1:0]   in_pos;

    logic [bis_pkg::CNT_W-1:0]   count_reg;
    logic [bis_pkg::CNT_W-1:0]   count_next;
    logic [bis_pkg::CNT_W-1:0]   capacity_reg;
    logic [bis_pkg::CNT_W-1:0]   idx_reg;
    logic                        ok_reg;
    logic                        ok_next;
    bis_pkg::opcode_t            op_reg;
    logic [bis_pkg::DATA_W-1:0]  key_reg;
    logic [bis_pkg::DATA_W-1:0]  rdata_reg;
    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic [bis_pkg::DATA_W-1:0]  out_data_reg;
    logic [bis_pkg::CNT_W-1:0]   out_count_reg;

    logic [bis_pkg::CNT_W-1:0]   limit;
    logic                        can_push;
    logic                        can_pop;
    logic                        can_read;
    logic                        scan_hit;
    logic [AW-1:0]               rd_addr;

    // input item fields
    assign in_op    = bis_pkg::opcode_t'(s_tdata[1:0]);
    assign in_value = s_tdata[33:2];
    assign in_pos   = s_tdata[41:34];

    // bounds checks
    assign limit    = (capacity_reg < DEPTH_LIM) ? capacity_reg : DEPTH_LIM;
    assign can_push = count_reg < limit;
    assign can_pop  = count_reg != '0;
    assign can_read = {1'b0, in_pos} < count_reg;
    assign scan_hit = rdata_reg == key_reg;

    // status to controller
    assign sts.search_go = (in_op == bis_pkg::OP_SEARCH) && can_pop;
    assign sts.scan_done = scan_hit || (idx_reg == count_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    // read address: scan walks up from the bottom, pop takes the top, read takes its position
    always_comb
    begin
        rd_addr = '0;
        if (cmd.scan)
        begin
            rd_addr = AW'(idx_reg);
        end
        else
        begin
            unique case (in_op)
                bis_pkg::OP_POP:  rd_addr = AW'(count_reg - 9'd1);
                bis_pkg::OP_READ: rd_addr = AW'(in_pos);
                default:          rd_addr = '0;
            endcase
        end
    end

    // outcome and count of a new item
    always_comb
    begin
        ok_next    = ok_reg;
        count_next = count_reg;
        if (cmd.start)
        begin
            unique case (in_op)
                bis_pkg::OP_PUSH:
                begin
                    ok_next = can_push;
                    if (can_push)
                    begin
                        count_next = count_reg + 9'd1;
                    end
                end
                bis_pkg::OP_POP:
                begin
                    ok_next = can_pop;
                    if (can_pop)
                    begin
                        count_next = count_reg - 9'd1;
                    end
                end
                bis_pkg::OP_READ:   ok_next = can_read;
                bis_pkg::OP_SEARCH: ok_next = 1'b0;
                default:            ok_next = 1'b0;
            endcase
        end
        else if (cmd.scan && scan_hit)
        begin
            ok_next = 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.start && (in_op == bis_pkg::OP_PUSH) && can_push)
        begin
            mem[AW'(count_reg)] <= in_value;
        end
        if (cmd.start || cmd.scan)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            capacity_reg  <= bis_pkg::CAPACITY_RST;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ok_reg    <= ok_next;
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item latch, scan index and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= in_op;
            key_reg <= in_value;
            idx_reg <= 9'd1;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + 9'd1;
        end
        if (cmd.finish)
        begin
            out_ok_reg    <= ok_reg;
            out_count_reg <= count_reg;
            if (ok_reg && ((op_reg == bis_pkg::OP_POP) || (op_reg == bis_pkg::OP_READ)))
            begin
                out_data_reg <= rdata_reg;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_count_reg, out_data_reg, out_ok_reg};

endmodule

`default_nettype wire

@@ rtl/bounded_integer_stack_top.sv @@
// a push, pop or read result waits in the result state until the output register is free
// a search first walks the store from the bottom to a hit or the top entry, then does the same
// one item at a time: a search holds the block while it walks the store
// the walk is set by the single read port of the entry store, one entry per cycle
// reset: asynchronous active low; count cleared, capacity set to 256, entries left as they are
`timescale 1ns / 1ps
`default_nettype none

module bounded_integer_stack_top #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // opcode[1:0], value[33:2], position[41:34], zero fill above
    input  wire logic [bis_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // ok[0], data[32:1], count[41:33], zero fill above
    output logic [bis_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bis_pkg::CNT_W-1:0]          cfg_data
);

    bis_pkg::ctrl_cmd_t cmd;
    bis_pkg::ctrl_sts_t sts;

    // capacity writes always taken
    assign cfg_ready = 1'b1;

    // sequencer
    bis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, count and output register
    bis_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/bis_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bis_checker #(
    parameter int unsigned DEPTH = 256
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous one in progress");

    // a failed operation returns zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
    else $error("failed result with nonzero data");

    // count never exceeds the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[41:33]) <= DEPTH)
    else $error("count beyond depth");

endmodule

bind bounded_integer_stack_top bis_checker #(
    .DEPTH (DEPTH)
) u_bis_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/bounded_integer_stack_checker.sv @@
`timescale 1ns / 1ps

// watches the stack's channels, predicts each reply and compares it
module bounded_integer_stack_checker
    import bis_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    // opcode[1:0], value[33:2], position[41:34], zero fill above
    input  wire logic [IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    // ok[0], data[32:1], count[41:33], zero fill above
    input  wire logic [OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [CNT_W-1:0]           cfg_data,
    output int                              fail_count,
    output int                              pending
);

    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned FILL_LSB    = 1 + DATA_W + CNT_W;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } reply_t;

    // shadow of the stack contents and its capacity register
    logic [DATA_W-1:0] shadow_entries [STORE_DEPTH];
    int unsigned       shadow_held;
    int unsigned       shadow_cap;
    reply_t            expected_replies [$];
    int                errors;

    // apply one operation to the shadow stack and return its reply
    function automatic reply_t stack_apply(opcode_t op, logic [DATA_W-1:0] val,
                                           logic [POS_W-1:0] pos);
        reply_t      r;
        int unsigned lim;
        r     = '0;
        lim   = (shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap;
        case (op)
            OP_PUSH:
            begin
                if (shadow_held < lim)
                begin
                    shadow_entries[shadow_held] = val;
                    shadow_held++;
                    r.ok = 1'b1;
                end
            end
            OP_POP:
            begin
                if (shadow_held > 0)
                begin
                    shadow_held--;
                    r.data = shadow_entries[shadow_held];
                    r.ok   = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos < shadow_held)
                begin
                    r.data = shadow_entries[pos];
                    r.ok   = 1'b1;
                end
            end
            default:
            begin
                // the whole held range, top entry included
                for (int unsigned i = 0; i < shadow_held; i++)
                begin
                    if (shadow_entries[i] == val)
                        r.ok = 1'b1;
                end
            end
        endcase
        r.count = shadow_held[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t                          want;
        logic [OUT_TDATA_W-FILL_LSB-1:0] fill;
        if (!rst_n)
        begin
            shadow_held = 0;
            shadow_cap  = CAPACITY_RST;
            expected_replies.delete();
            errors      = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // compare an accepted reply with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply with no item outstanding: tdata %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    fill = m_tdata[OUT_TDATA_W-1:FILL_LSB];
                    if (m_tdata[0] !== want.ok)
                    begin
                        $error("ok mismatch: expected %0d, actual %0d", want.ok, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[DATA_W:1] !== want.data)
                    begin
                        $error("data mismatch: expected %0d, actual %0d",
                               $signed(want.data), $signed(m_tdata[DATA_W:1]));
                        errors++;
                    end
                    if (m_tdata[DATA_W+CNT_W:DATA_W+1] !== want.count)
                    begin
                        $error("count mismatch: expected %0d, actual %0d",
                               want.count, m_tdata[DATA_W+CNT_W:DATA_W+1]);
                        errors++;
                    end
                    if (fill !== '0)
                    begin
                        $error("fill mismatch: expected 0, actual %h", fill);
                        errors++;
                    end
                end
            end
            // predict the reply of an accepted item
            if (s_tvalid && s_tready)
                expected_replies.push_back(stack_apply(opcode_t'(s_tdata[OP_W-1:0]),
                                                       s_tdata[OP_W+DATA_W-1:OP_W],
                                                       s_tdata[OP_W+DATA_W+POS_W-1:OP_W+DATA_W]));
            // capacity write
            if (cfg_valid && cfg_ready)
                shadow_cap = cfg_data;
            fail_count <= errors;
            pending    <= expected_replies.size();
        end
    end

endmodule

@@ tb/sv/tb_bounded_integer_stack_top.sv @@
`timescale 1ns / 1ps

module tb_bounded_integer_stack_top;
    import bis_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_LEN [N_PHASES] = '{60, 320, 20, 40, 60, 60, 60, 60, 40, 80};
    localparam int PHASE_PUSH [N_PHASES] = '{55, 75, 50, 50, 55, 60, 30, 60, 45, 50};
    localparam logic [CNT_W-1:0] PHASE_CAP [N_PHASES] =
        '{9'd3, 9'd256, 9'd0, 9'd1, 9'd17, 9'd511, 9'd200, 9'd257, 9'd2, 9'd64};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data  = '0;

    int                     fail_count;
    int                     pending;
    logic                   idle_en   = 1'b1;
    int                     ready_left = 0;
    int                     quiet_cycles = 0;

    // recently pushed values, so searches and duplicates hit
    logic [DATA_W-1:0]      recent_vals [16];
    int                     recent_wr = 0;

    always #1 clk = ~clk;

    bounded_integer_stack_top #(
        .DEPTH(256)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    bounded_integer_stack_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // reply side: ready stretches and stall bursts
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            if (idle_en && $urandom_range(0, 2) == 0)
            begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(1, 12);
            end
            else
            begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 24);
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom_range(0, 15) - 32'd8;
            4, 5:    return recent_vals[$urandom_range(0, 15)];
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 3))
            0, 1:    return POS_W'($urandom_range(0, 7));
            2:       return POS_W'($urandom_range(0, 63));
            default: return POS_W'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one item, with an optional gap in front of it
    task automatic send_item(input opcode_t op, input logic [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-OP_W-DATA_W-POS_W){1'b0}}, pos, val, op};
        if (op == OP_PUSH)
        begin
            recent_vals[recent_wr] = val;
            recent_wr = (recent_wr + 1) % 16;
        end
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and wait for every reply
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          r;
        opcode_t     op;
        logic [DATA_W-1:0] v;
        for (int i = 0; i < 16; i++)
            recent_vals[i] = $urandom();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty stack at reset capacity
        send_item(OP_POP, 32'd0, 8'd0);
        send_item(OP_READ, 32'd0, 8'd0);
        send_item(OP_SEARCH, 32'd0, 8'd0);
        // value extremes
        send_item(OP_PUSH, 32'h8000_0000, 8'd0);
        send_item(OP_PUSH, 32'h7fff_ffff, 8'd0);
        send_item(OP_PUSH, 32'd0, 8'd0);
        send_item(OP_PUSH, 32'hffff_ffff, 8'd0);
        // reads inside, at and past the count
        send_item(OP_READ, 32'd0, 8'd0);
        send_item(OP_READ, 32'd0, 8'd3);
        send_item(OP_READ, 32'd0, 8'd4);
        send_item(OP_READ, 32'd0, 8'd255);
        // search hits on top and bottom, then a miss
        send_item(OP_SEARCH, 32'hffff_ffff, 8'd0);
        send_item(OP_SEARCH, 32'h8000_0000, 8'd0);
        send_item(OP_SEARCH, 32'd12345, 8'd0);
        send_item(OP_POP, 32'd0, 8'd0);
        // capacity lowered below the count
        write_capacity(9'd2);
        send_item(OP_PUSH, 32'd77, 8'd0);
        send_item(OP_READ, 32'd0, 8'd2);
        send_item(OP_SEARCH, 32'd0, 8'd0);
        send_item(OP_POP, 32'd0, 8'd0);
        // capacity zero is always full
        write_capacity(9'd0);
        send_item(OP_PUSH, 32'd5, 8'd0);
        send_item(OP_POP, 32'd0, 8'd0);
        // capacity above the depth
        write_capacity(9'd511);
        send_item(OP_PUSH, 32'd5, 8'd0);
        send_item(OP_PUSH, 32'd6, 8'd0);
        send_item(OP_READ, 32'd0, 8'd2);

        // random phases, each under its own capacity
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_capacity(p == 6 ? CNT_W'($urandom_range(1, 256)) : PHASE_CAP[p]);
            if (p == N_PHASES - 1)
                idle_en <= 1'b0;
            for (int k = 0; k < PHASE_LEN[p]; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < PHASE_PUSH[p])
                    op = OP_PUSH;
                else
                begin
                    case (r % 3)
                        0:       op = OP_POP;
                        1:       op = OP_READ;
                        default: op = OP_SEARCH;
                    endcase
                end
                if (op == OP_SEARCH && $urandom_range(0, 1) == 1)
                    v = recent_vals[$urandom_range(0, 15)];
                else
                    v = pick_value();
                send_item(op, v, pick_position());
            end
        end

        // drain and give the verdict
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
